@@ rtl/core/ibm_pkg.sv @@
// Shared constants, opcodes and a helper function for the inode bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ibm_pkg;

    localparam int MAX_INODES = 1024;
    localparam int ROW_BITS   = 32;
    localparam int NROWS      = MAX_INODES / ROW_BITS + 1;
    localparam int ROW_AW     = $clog2(NROWS);
    localparam int COL_W      = $clog2(ROW_BITS);
    localparam int ID_W       = 10;
    localparam int CNT_W      = 11;
    localparam int OP_W       = 3;

    localparam logic [ROW_BITS-1:0] ROW_ONES = 32'hffffffff;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [ROW_BITS-1:0] t_row;
    typedef logic [ROW_AW-1:0]   t_row_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

    localparam t_op OP_ALLOC      = 3'd0;
    localparam t_op OP_RECLAIM    = 3'd1;
    localparam t_op OP_LOAD_ROW   = 3'd2;
    localparam t_op OP_READ_ROW   = 3'd3;
    localparam t_op OP_LOAD_SPARE = 3'd4;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] idx;
    } t_ffz;

    // Lowest clear bit of a row word.
    function automatic t_ffz find_first_zero(input t_row w);
        t_ffz r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            if (!w[j]) begin
                r.found = 1'b1;
                r.idx   = COL_W'(j);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ibm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ibm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/inode_bitmap_allocator.sv @@
// Top level of the first-fit inode bitmap allocator.
//
// Usage:
//   Command channel: drive i_op and the operand ports with start high; the
//   command is taken at a rising edge where start is high and busy is low.
//   Busy stays high while the command is at work.
//   Result: o_done is high for exactly one cycle with o_ok, o_alloc_id,
//   o_row_word_out and o_spare_count valid; the receiver cannot stall.
//   Config: the inode limit is written over i_cfg_valid / o_cfg_ready /
//   i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Sequencing:
//   load row, load spare, undefined op, allocate with zero limit: no busy state.
//   reclaim, read row: pass through S_CHECK or S_READ.
//   allocate: stays in S_SCAN, at most 32 rows scanned at a 1024 limit;
//   the scan reads one bitmap row per cycle from the RAM read port while the
//   priority encoder checks the previous row, and the grant writes back in
//   the cycle that finds it. A new command can be taken in the o_done cycle.
// Reset: the bitmap reads as all zeros (per-row valid flops cleared), the
//   spare counter is zero and the limit is 1024.
`timescale 1ns / 1ps
`default_nettype none

module inode_bitmap_allocator (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire ibm_pkg::t_op         i_op,
    input  wire [ibm_pkg::ID_W-1:0]   i_inode_id,
    input  wire [5:0]                 i_row_index,
    input  wire ibm_pkg::t_row        i_row_word,
    input  wire ibm_pkg::t_cnt        i_spare_value,
    output logic                      o_done,
    output logic                      o_ok,
    output logic [ibm_pkg::ID_W-1:0]  o_alloc_id,
    output ibm_pkg::t_row             o_row_word_out,
    output ibm_pkg::t_cnt             o_spare_count,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire ibm_pkg::t_cnt        i_cfg_data
);

    import ibm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]       r_state, n_state;
    t_cnt             r_limit;
    t_cnt             r_spare, n_spare;
    logic [NROWS-1:0] r_vld, n_vld;
    logic             r_done, n_done;
    logic             r_ok, n_ok;
    logic [ID_W-1:0]  r_aid, n_aid;
    t_row             r_word, n_word;
    logic [ID_W-1:0]  r_id, n_id;
    logic [5:0]       r_row, n_row;
    t_row_addr        r_ev_row, n_ev_row;
    t_row_addr        r_last_row, n_last_row;

    logic      ram_we;
    t_row_addr ram_waddr;
    t_row      ram_wdata;
    logic      ram_re;
    t_row_addr ram_raddr;
    t_row      ram_q;

    t_cnt             eff_lim;
    t_row_addr        lim_row;
    logic [COL_W-1:0] lim_bit;
    t_row_addr        lim_last;
    t_row             lim_mask;
    t_row             stored;
    t_row             taken;
    t_ffz             ffz;
    t_row_addr        chk_row;
    logic [COL_W-1:0] chk_col;
    t_cnt             spare_sat;

    ibm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_alloc_id     = r_aid;
    assign o_row_word_out = r_word;
    assign o_spare_count  = r_spare;

    assign eff_lim   = (r_limit > CNT_W'(MAX_INODES)) ? CNT_W'(MAX_INODES) : r_limit;
    assign lim_row   = ROW_AW'(eff_lim >> COL_W);
    assign lim_bit   = eff_lim[COL_W-1:0];
    assign lim_last  = (lim_bit == '0) ? (lim_row - ROW_AW'(1)) : lim_row;
    assign spare_sat = (i_spare_value > CNT_W'(MAX_INODES)) ? CNT_W'(MAX_INODES)
                                                            : i_spare_value;
    assign chk_row   = ROW_AW'(r_id[ID_W-1:COL_W]);
    assign chk_col   = r_id[COL_W-1:0];

    always_comb begin
        priority if (r_ev_row < lim_row) begin
            lim_mask = '0;
        end else if (r_ev_row == lim_row) begin
            lim_mask = ROW_ONES << lim_bit;
        end else begin
            lim_mask = ROW_ONES;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_spare    = r_spare;
        n_vld      = r_vld;
        n_done     = 1'b0;
        n_ok       = r_ok;
        n_aid      = r_aid;
        n_word     = r_word;
        n_id       = r_id;
        n_row      = r_row;
        n_ev_row   = r_ev_row;
        n_last_row = r_last_row;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        stored     = '0;
        taken      = '0;
        ffz        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ok   = 1'b0;
                    n_aid  = '0;
                    n_word = '0;
                    unique case (i_op)
                        OP_ALLOC: begin
                            if (eff_lim == '0) begin
                                n_done = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                n_ev_row   = '0;
                                n_last_row = lim_last;
                                n_state    = S_SCAN;
                            end
                        end
                        OP_RECLAIM: begin
                            ram_re    = 1'b1;
                            ram_raddr = ROW_AW'(i_inode_id[ID_W-1:COL_W]);
                            n_id      = i_inode_id;
                            n_state   = S_CHECK;
                        end
                        OP_LOAD_ROW: begin
                            if (i_row_index < 6'(NROWS)) begin
                                ram_we    = 1'b1;
                                ram_waddr = ROW_AW'(i_row_index);
                                ram_wdata = i_row_word;
                                n_vld[ROW_AW'(i_row_index)] = 1'b1;
                                n_ok      = 1'b1;
                            end
                            n_done = 1'b1;
                        end
                        OP_READ_ROW: begin
                            n_row = i_row_index;
                            if (i_row_index < 6'(NROWS)) begin
                                ram_re    = 1'b1;
                                ram_raddr = ROW_AW'(i_row_index);
                            end
                            n_state = S_READ;
                        end
                        OP_LOAD_SPARE: begin
                            n_spare = spare_sat;
                            n_ok    = 1'b1;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                stored = ram_q & {ROW_BITS{r_vld[r_ev_row]}};
                taken  = stored | lim_mask;
                ffz    = find_first_zero(taken);
                priority if (ffz.found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ev_row;
                    ram_wdata = stored | (t_row'(1) << ffz.idx);
                    n_vld[r_ev_row] = 1'b1;
                    n_ok      = 1'b1;
                    n_aid     = {r_ev_row[ID_W-COL_W-1:0], ffz.idx};
                    if (r_spare != '0) begin
                        n_spare = r_spare - CNT_W'(1);
                    end
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_ev_row == r_last_row) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ev_row + ROW_AW'(1);
                    n_ev_row  = r_ev_row + ROW_AW'(1);
                end
            end
            S_CHECK: begin
                stored = ram_q & {ROW_BITS{r_vld[chk_row]}};
                if (({1'b0, r_id} < eff_lim) && stored[chk_col]) begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_row;
                    ram_wdata = stored & ~(t_row'(1) << chk_col);
                    n_vld[chk_row] = 1'b1;
                    n_ok      = 1'b1;
                    if (r_spare < CNT_W'(MAX_INODES)) begin
                        n_spare = r_spare + CNT_W'(1);
                    end
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                if (r_row < 6'(NROWS)) begin
                    n_ok   = 1'b1;
                    n_word = ram_q & {ROW_BITS{r_vld[ROW_AW'(r_row)]}};
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= CNT_W'(1024);
            r_spare <= '0;
            r_vld   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_spare <= n_spare;
            r_vld   <= n_vld;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok       <= n_ok;
        r_aid      <= n_aid;
        r_word     <= n_word;
        r_id       <= n_id;
        r_row      <= n_row;
        r_ev_row   <= n_ev_row;
        r_last_row <= n_last_row;
    end

endmodule

`default_nettype wire

@@ tb/inode_bitmap_allocator_tb.sv @@
// Self-checking testbench for the first-fit inode bitmap allocator.
`timescale 1ns / 1ps

module inode_bitmap_allocator_tb;
    import ibm_pkg::*;

    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] alloc_id;
        t_row            row_word;
        t_cnt            spare;
    } t_alloc_outcome;

    class allocator_scoreboard;
        t_row           used_rows[NROWS];
        t_cnt           spare_count;
        t_cnt           inode_limit;
        t_alloc_outcome pending_q[$];
        int             mismatches;

        function new();
            foreach (used_rows[r]) used_rows[r] = '0;
            spare_count = '0;
            inode_limit = t_cnt'(MAX_INODES);
            mismatches  = 0;
        endfunction

        function int eff_limit();
            return (inode_limit > MAX_INODES) ? MAX_INODES : int'(inode_limit);
        endfunction

        function bit is_used(int k);
            return used_rows[k / ROW_BITS][k % ROW_BITS];
        endfunction

        function int pick_used_id(int from);
            int lim;
            int k;
            lim = eff_limit();
            for (int n = 0; n < lim; n++) begin
                k = (from + n) % lim;
                if (is_used(k)) return k;
            end
            return -1;
        endfunction

        function void note_command(t_op op, logic [ID_W-1:0] id, logic [5:0] row,
                                   t_row word, t_cnt spare_in);
            t_alloc_outcome want;
            int lim;
            bit found;
            want  = '0;
            lim   = eff_limit();
            found = 1'b0;
            case (op)
                OP_ALLOC: begin
                    for (int k = 0; k < lim && !found; k++) begin
                        if (!is_used(k)) begin
                            used_rows[k / ROW_BITS][k % ROW_BITS] = 1'b1;
                            want.ok       = 1'b1;
                            want.alloc_id = ID_W'(k);
                            found         = 1'b1;
                            if (spare_count != 0) spare_count--;
                        end
                    end
                end
                OP_RECLAIM: begin
                    if (id < lim && is_used(int'(id))) begin
                        used_rows[id / ROW_BITS][id % ROW_BITS] = 1'b0;
                        want.ok = 1'b1;
                        if (spare_count < MAX_INODES) spare_count++;
                    end
                end
                OP_LOAD_ROW: begin
                    if (row < NROWS) begin
                        used_rows[row] = word;
                        want.ok = 1'b1;
                    end
                end
                OP_READ_ROW: begin
                    if (row < NROWS) begin
                        want.row_word = used_rows[row];
                        want.ok       = 1'b1;
                    end
                end
                OP_LOAD_SPARE: begin
                    spare_count = (spare_in > MAX_INODES) ? t_cnt'(MAX_INODES) : spare_in;
                    want.ok = 1'b1;
                end
                default: ;
            endcase
            want.spare = spare_count;
            pending_q.push_back(want);
        endfunction

        function void check_result(logic ok, logic [ID_W-1:0] id, t_row word, t_cnt spare);
            t_alloc_outcome want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result ok=%0b id=%0d word=%h spare=%0d",
                             ok, id, word, spare);
                return;
            end
            want = pending_q.pop_front();
            if (ok !== want.ok || id !== want.alloc_id || word !== want.row_word ||
                spare !== want.spare) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected ok=%0b id=%0d word=%h spare=%0d, ",
                              "got ok=%0b id=%0d word=%h spare=%0d"},
                             want.ok, want.alloc_id, want.row_word, want.spare,
                             ok, id, word, spare);
            end
        endfunction
    endclass

    localparam int  STALL_LIMIT        = 2000;
    localparam int  RANDOM_PHASE_ITEMS = 72;
    localparam t_op OP_RESERVED_FIRST  = 3'd5;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            start         = 1'b0;
    logic            busy;
    t_op             i_op          = OP_ALLOC;
    logic [ID_W-1:0] i_inode_id    = '0;
    logic [5:0]      i_row_index   = '0;
    t_row            i_row_word    = '0;
    t_cnt            i_spare_value = '0;
    logic            o_done;
    logic            o_ok;
    logic [ID_W-1:0] o_alloc_id;
    t_row            o_row_word_out;
    t_cnt            o_spare_count;
    logic            i_cfg_valid   = 1'b0;
    logic            o_cfg_ready;
    t_cnt            i_cfg_data    = '0;

    allocator_scoreboard sb;
    int                  stall_cycles = 0;

    inode_bitmap_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_inode_id     (i_inode_id),
        .i_row_index    (i_row_index),
        .i_row_word     (i_row_word),
        .i_spare_value  (i_spare_value),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_alloc_id     (o_alloc_id),
        .o_row_word_out (o_row_word_out),
        .o_spare_count  (o_spare_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_ok, o_alloc_id, o_row_word_out, o_spare_count);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue(t_op op, logic [ID_W-1:0] id, logic [5:0] row, t_row word,
                         t_cnt spare);
        start         <= 1'b1;
        i_op          <= op;
        i_inode_id    <= id;
        i_row_index   <= row;
        i_row_word    <= word;
        i_spare_value <= spare;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, id, row, word, spare);
    endtask

    task automatic rest(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0);
    endtask

    task automatic write_limit(t_cnt value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.inode_limit = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_row random_word();
        case ($urandom_range(0, 3))
            0:       return ROW_ONES;
            1:       return $urandom | $urandom;
            2:       return ~(t_row'(1) << $urandom_range(0, ROW_BITS - 1));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_command();
        int              sel;
        int              pick;
        t_op             op;
        logic [ID_W-1:0] id;
        logic [5:0]      row;
        t_row            word;
        t_cnt            spare;
        sel   = $urandom_range(0, 99);
        id    = ID_W'($urandom);
        row   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(NROWS, 63))
                                            : 6'($urandom_range(0, NROWS - 1));
        word  = random_word();
        spare = t_cnt'($urandom);
        if (sel < 38) begin
            op = OP_ALLOC;
        end else if (sel < 58) begin
            op   = OP_RECLAIM;
            pick = sb.pick_used_id($urandom_range(0, MAX_INODES - 1));
            if (pick >= 0 && $urandom_range(0, 9) < 7) id = ID_W'(pick);
        end else if (sel < 70) begin
            op = OP_LOAD_ROW;
        end else if (sel < 84) begin
            op = OP_READ_ROW;
        end else if (sel < 95) begin
            op = OP_LOAD_SPARE;
        end else begin
            op = t_op'(OP_RESERVED_FIRST + $urandom_range(0, 2));
        end
        issue(op, id, row, word, spare);
    endtask

    task automatic random_phase(t_cnt limit, bit calm);
        int mode;
        int fill;
        write_limit(limit);
        mode = $urandom_range(0, 2);
        fill = $urandom_range(1, NROWS);
        for (int r = 0; r < fill && mode != 0; r++) begin
            issue(OP_LOAD_ROW, ID_W'($urandom), 6'(r),
                  (mode == 2) ? '0 : (($urandom_range(0, 3) == 0) ? random_word() : ROW_ONES),
                  t_cnt'($urandom));
        end
        for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
            if (!calm && $urandom_range(0, 99) < 30) rest($urandom_range(1, 16));
            if (!calm && $urandom_range(0, 99) == 0) drain();
            random_command();
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_READ_ROW,      '0,        6'd0,  '0,           '0);
        issue(OP_LOAD_SPARE,    '0,        6'd0,  '0,           11'd2047);
        issue(OP_RECLAIM,       '0,        6'd0,  '0,           '0);
        issue(OP_ALLOC,         '1,        6'd63, '1,           '1);
        issue(OP_ALLOC,         '0,        6'd0,  '0,           '0);
        issue(OP_RECLAIM,       10'd1,     6'd0,  '0,           '0);
        issue(OP_LOAD_SPARE,    '0,        6'd0,  '0,           '0);
        issue(OP_ALLOC,         '0,        6'd0,  '0,           '0);
        issue(OP_LOAD_SPARE,    '0,        6'd0,  '0,           11'd1024);
        issue(OP_RECLAIM,       '0,        6'd0,  '0,           '0);
        issue(OP_RECLAIM,       10'd1023,  6'd0,  '0,           '0);
        issue(OP_LOAD_ROW,      '0,        6'd32, ROW_ONES,     '0);
        issue(OP_READ_ROW,      '0,        6'd32, '0,           '0);
        issue(OP_LOAD_ROW,      '0,        6'd33, ROW_ONES,     '0);
        issue(OP_READ_ROW,      '0,        6'd63, '0,           '0);
        issue(OP_RESERVED_FIRST,     '1,   6'd63, '1,           '1);
        issue(t_op'(OP_RESERVED_FIRST + 1), '0, 6'd0, '0,        '0);
        issue(t_op'(OP_RESERVED_FIRST + 2), '0, 6'd0, '0,        '0);

        write_limit(11'd40);
        issue(OP_LOAD_ROW,      '0,        6'd0,  ROW_ONES,     '0);
        issue(OP_LOAD_ROW,      '0,        6'd1,  32'h000000ff, '0);
        issue(OP_LOAD_ROW,      '0,        6'd2,  32'ha5a5a5a5, '0);
        issue(OP_ALLOC,         '0,        6'd0,  '0,           '0);
        issue(OP_RECLAIM,       10'd64,    6'd0,  '0,           '0);
        issue(OP_RECLAIM,       10'd39,    6'd0,  '0,           '0);
        issue(OP_ALLOC,         '0,        6'd0,  '0,           '0);
        issue(OP_READ_ROW,      '0,        6'd2,  '0,           '0);
        write_limit(11'd2047);
        issue(OP_ALLOC,         '0,        6'd0,  '0,           '0);

        random_phase(11'd1024, 1'b0);
        random_phase(11'd33,   1'b1);
        random_phase(11'd0,    1'b0);
        random_phase(11'd2047, 1'b0);
        random_phase(11'd1,    1'b0);
        random_phase(11'd32,   1'b1);
        random_phase(11'd517,  1'b0);
        random_phase(11'd31,   1'b0);
        random_phase(11'd1023, 1'b0);
        random_phase(11'd1024, 1'b1);

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
